// ===== rtl/gae_pkg.sv =====
// ----------------------------------------------------------------------------
// gae_pkg
// Shared types and constants for the gather-elements address generator.
// ----------------------------------------------------------------------------
package gae_pkg;

    localparam int DIM_BITS  = 16;
    localparam int ADDR_BITS = 32;

    localparam int PADDR_W = 5;

    // register index codes
    localparam logic [2:0] REG_NUM_DIMS       = 3'd0;
    localparam logic [2:0] REG_GATHER_AXIS    = 3'd1;
    localparam logic [2:0] REG_OUT_WIDTH      = 3'd2;
    localparam logic [2:0] REG_OUT_HEIGHT     = 3'd3;
    localparam logic [2:0] REG_DATA_WIDTH     = 3'd4;
    localparam logic [2:0] REG_DATA_HEIGHT    = 3'd5;
    localparam logic [2:0] REG_DATA_CHANNELS  = 3'd6;
    localparam logic [2:0] REG_CHANNEL_STRIDE = 3'd7;

    // gather axis counted from the innermost end
    localparam logic [1:0] INNER_X = 2'd0;
    localparam logic [1:0] INNER_Y = 2'd1;

    typedef struct packed {
        logic signed [31:0] gather_index;
        logic               last_element;
    } in_word_t;

    typedef struct packed {
        logic [31:0] source_address;
        logic        out_of_range;
        logic        axis_error;
        logic        last_result;
    } out_word_t;

endpackage

// ===== rtl/gae_in_if.sv =====
// ----------------------------------------------------------------------------
// gae_in_if
// Valid/ready channel carrying one gather index word.
// ----------------------------------------------------------------------------
interface gae_in_if
    import gae_pkg::*;
    ;
    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gae_out_if.sv =====
// ----------------------------------------------------------------------------
// gae_out_if
// Valid/ready channel carrying one source address word.
// ----------------------------------------------------------------------------
interface gae_out_if
    import gae_pkg::*;
    ;
    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gather_elements_address_gen.sv =====
// ----------------------------------------------------------------------------
// gather_elements_address_gen
// Turns signed gather indices, in raster order, into flat source addresses.
// ----------------------------------------------------------------------------
// Takes one index word per cycle while the output is not stalled and returns one
// address word per index. The path is four registers deep: input register,
// index check and coordinate substitution, the two multiplies by data width and
// channel stride, and the final add into the output register. The address word
// moves from the input register through the stage 2 and stage 3 registers into
// the output register. With the output ready, one word is taken and one returned
// every cycle. When the output stalls, later words move up into empty stages;
// in_ch.ready drops once all four stages hold a word and rises in the same cycle
// that the output word is taken. The user must write configuration over the APB
// port only while the block is idle; the block itself does not enforce it.
module gather_elements_address_gen
    import gae_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    gae_in_if.sink             in_ch,
    gae_out_if.source          out_ch
);

    localparam int IDX_W = 34;
    localparam int PZ_W  = DIM_BITS + 32;
    localparam int PY_W  = DIM_BITS + 16;
    localparam int CW    = 33;

    typedef struct packed {
        logic signed [31:0]  idx;
        logic                last;
        logic [DIM_BITS-1:0] x;
        logic [DIM_BITS-1:0] y;
        logic [DIM_BITS-1:0] z;
    } s1_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] x;
        logic [DIM_BITS-1:0] y;
        logic [DIM_BITS-1:0] z;
        logic                oor;
        logic                aerr;
        logic                last;
    } s2_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] x;
        logic [ADDR_BITS-1:0] py;
        logic [ADDR_BITS-1:0] pz;
        logic                 oor;
        logic                 aerr;
        logic                 last;
    } s3_t;

    // configuration registers
    logic [1:0]        num_dims_reg;
    logic signed [2:0] gather_axis_reg;
    logic [15:0]       out_width_reg;
    logic [15:0]       out_height_reg;
    logic [15:0]       data_width_reg;
    logic [15:0]       data_height_reg;
    logic [15:0]       data_channels_reg;
    logic [31:0]       channel_stride_reg;

    logic       cfg_wr;
    logic [2:0] cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg       <= 2'd1;
            gather_axis_reg    <= 3'sd0;
            out_width_reg      <= 16'd1;
            out_height_reg     <= 16'd1;
            data_width_reg     <= 16'd1;
            data_height_reg    <= 16'd1;
            data_channels_reg  <= 16'd1;
            channel_stride_reg <= 32'd1;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_NUM_DIMS:       num_dims_reg       <= pwdata[1:0];
                REG_GATHER_AXIS:    gather_axis_reg    <= pwdata[2:0];
                REG_OUT_WIDTH:      out_width_reg      <= pwdata[15:0];
                REG_OUT_HEIGHT:     out_height_reg     <= pwdata[15:0];
                REG_DATA_WIDTH:     data_width_reg     <= pwdata[15:0];
                REG_DATA_HEIGHT:    data_height_reg    <= pwdata[15:0];
                REG_DATA_CHANNELS:  data_channels_reg  <= pwdata[15:0];
                REG_CHANNEL_STRIDE: channel_stride_reg <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_NUM_DIMS:       prdata = {30'd0, num_dims_reg};
            REG_GATHER_AXIS:    prdata = {29'd0, gather_axis_reg};
            REG_OUT_WIDTH:      prdata = {16'd0, out_width_reg};
            REG_OUT_HEIGHT:     prdata = {16'd0, out_height_reg};
            REG_DATA_WIDTH:     prdata = {16'd0, data_width_reg};
            REG_DATA_HEIGHT:    prdata = {16'd0, data_height_reg};
            REG_DATA_CHANNELS:  prdata = {16'd0, data_channels_reg};
            REG_CHANNEL_STRIDE: prdata = channel_stride_reg;
            default:            prdata = 32'd0;
        endcase
    end

    // pipeline handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, out_ready_int;
    logic in_accept;

    assign out_ready_int = !out_valid_reg || out_ch.ready;
    assign s3_ready      = !s3_valid_reg || out_ready_int;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign in_ch.ready   = s1_ready;
    assign in_accept     = in_ch.valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready_int)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // raster position counters
    logic [DIM_BITS-1:0] col_count_reg, row_count_reg, chan_count_reg;
    logic [DIM_BITS-1:0] col_count_next, row_count_next, chan_count_next;
    logic                col_wrap, row_wrap;

    always_comb
    begin
        col_wrap        = (CW'(col_count_reg) + CW'(1)) >= CW'(out_width_reg);
        row_wrap        = (CW'(row_count_reg) + CW'(1)) >= CW'(out_height_reg);
        col_count_next  = col_count_reg;
        row_count_next  = row_count_reg;
        chan_count_next = chan_count_reg;
        if (in_ch.data.last_element)
        begin
            col_count_next  = '0;
            row_count_next  = '0;
            chan_count_next = '0;
        end
        else if (col_wrap)
        begin
            col_count_next = '0;
            if (row_wrap)
            begin
                row_count_next  = '0;
                chan_count_next = chan_count_reg + DIM_BITS'(1);
            end
            else
            begin
                row_count_next = row_count_reg + DIM_BITS'(1);
            end
        end
        else
        begin
            col_count_next = col_count_reg + DIM_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            chan_count_reg <= '0;
        end
        else if (in_accept)
        begin
            col_count_reg  <= col_count_next;
            row_count_reg  <= row_count_next;
            chan_count_reg <= chan_count_next;
        end
    end

    // stage 1: input register with position snapshot
    s1_t s1_reg;

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_reg.idx  <= in_ch.data.gather_index;
            s1_reg.last <= in_ch.data.last_element;
            s1_reg.x    <= col_count_reg;
            s1_reg.y    <= row_count_reg;
            s1_reg.z    <= chan_count_reg;
        end
    end

    // stage 2: axis resolve, index check, coordinate substitution
    logic signed [3:0]       axis_ext, axis_adj;
    logic                    aerr;
    logic [1:0]              inner;
    logic [15:0]             axis_len;
    logic signed [IDX_W-1:0] idx_ext, len_ext, idx_adj;
    logic                    oor;
    s2_t                     s2_next;
    s2_t                     s2_reg;

    always_comb
    begin
        axis_ext = {gather_axis_reg[2], gather_axis_reg};
        axis_adj = gather_axis_reg[2] ? (axis_ext + $signed({2'b00, num_dims_reg}))
                                      : axis_ext;
        aerr     = axis_adj[3] || (axis_adj[2:0] >= {1'b0, num_dims_reg});
        inner    = num_dims_reg - 2'd1 - axis_adj[1:0];
        case (inner)
            INNER_X: axis_len = data_width_reg;
            INNER_Y: axis_len = data_height_reg;
            default: axis_len = data_channels_reg;
        endcase
        idx_ext = IDX_W'(s1_reg.idx);
        len_ext = $signed({{(IDX_W - 16){1'b0}}, axis_len});
        idx_adj = s1_reg.idx[31] ? (idx_ext + len_ext) : idx_ext;
        oor     = !aerr && (idx_adj[IDX_W-1] || (idx_adj >= len_ext));

        s2_next.x    = s1_reg.x;
        s2_next.y    = s1_reg.y;
        s2_next.z    = s1_reg.z;
        s2_next.oor  = oor;
        s2_next.aerr = aerr;
        s2_next.last = s1_reg.last;
        case (inner)
            INNER_X: s2_next.x = idx_adj[DIM_BITS-1:0];
            INNER_Y: s2_next.y = idx_adj[DIM_BITS-1:0];
            default: s2_next.z = idx_adj[DIM_BITS-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_reg <= s2_next;
        end
    end

    // stage 3: products
    logic [PY_W-1:0] py_full;
    logic [PZ_W-1:0] pz_full;
    s3_t             s3_reg;

    assign py_full = PY_W'(s2_reg.y) * PY_W'(data_width_reg);
    assign pz_full = PZ_W'(s2_reg.z) * PZ_W'(channel_stride_reg);

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_reg.x    <= ADDR_BITS'(s2_reg.x);
            s3_reg.py   <= (num_dims_reg >= 2'd2) ? ADDR_BITS'(py_full) : '0;
            s3_reg.pz   <= (num_dims_reg >= 2'd3) ? ADDR_BITS'(pz_full) : '0;
            s3_reg.oor  <= s2_reg.oor;
            s3_reg.aerr <= s2_reg.aerr;
            s3_reg.last <= s2_reg.last;
        end
    end

    // output register: final sum
    logic [ADDR_BITS-1:0] addr_sum;
    out_word_t            out_reg;

    assign addr_sum = s3_reg.x + s3_reg.py + s3_reg.pz;

    always_ff @(posedge clk)
    begin
        if (out_ready_int)
        begin
            out_reg.source_address <= (s3_reg.oor || s3_reg.aerr) ? 32'd0
                                                                  : 32'(addr_sum);
            out_reg.out_of_range   <= s3_reg.oor;
            out_reg.axis_error     <= s3_reg.aerr;
            out_reg.last_result    <= s3_reg.last;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gather-elements address generator.
// ----------------------------------------------------------------------------
// Programs tensor shapes over APB, streams gather indices in raster order and
// compares every returned address word against a cycle-free model of the
// x/y/z counters, axis resolution and address arithmetic. Covers reset
// defaults, directed corner cases, then random tensors under several mixes
// of sender gaps and receiver backpressure.
module tb_top;
    import gae_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 10;
    localparam int WORDS_PER_PHASE = 220;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    gae_in_if  in_ch ();
    gae_out_if out_ch ();

    gather_elements_address_gen dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // shadow of the register file
    logic [1:0]        cfg_dims;
    logic signed [2:0] cfg_axis;
    logic [15:0]       cfg_out_w;
    logic [15:0]       cfg_out_h;
    logic [15:0]       cfg_data_w;
    logic [15:0]       cfg_data_h;
    logic [15:0]       cfg_data_c;
    logic [31:0]       cfg_stride;

    // output raster position
    logic [15:0] col_pos;
    logic [15:0] row_pos;
    logic [15:0] chan_pos;

    out_word_t pending_addresses[$];
    int        mismatch_count;
    int        stall_cycles;
    int        src_idle_pct;
    int        stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // gather axis position from the innermost end, -1 when invalid
    function automatic int gather_inner();
        int dims;
        int ax;
        dims = cfg_dims;
        ax = cfg_axis;
        if (ax < 0)
            ax = ax + dims;
        if (ax < 0 || ax >= dims)
            return -1;
        return dims - 1 - ax;
    endfunction

    function automatic longint axis_length(int inner);
        case (inner)
            0: return cfg_data_w;
            1: return cfg_data_h;
            default: return cfg_data_c;
        endcase
    endfunction

    function automatic out_word_t predict_address(logic signed [31:0] gidx, logic last);
        out_word_t       r;
        int              inner;
        longint          idx;
        longint          len;
        longint unsigned x;
        longint unsigned y;
        longint unsigned z;
        longint unsigned addr;
        r = '0;
        r.last_result = last;
        inner = gather_inner();
        if (inner < 0)
            r.axis_error = 1'b1;
        else
        begin
            len = axis_length(inner);
            idx = gidx;
            if (idx < 0)
                idx = idx + len;
            if (idx < 0 || idx >= len)
                r.out_of_range = 1'b1;
            else
            begin
                x = col_pos;
                y = row_pos;
                z = chan_pos;
                case (inner)
                    0: x = idx;
                    1: y = idx;
                    default: z = idx;
                endcase
                addr = x;
                if (cfg_dims >= 2)
                    addr = addr + y * cfg_data_w;
                if (cfg_dims >= 3)
                    addr = addr + z * cfg_stride;
                r.source_address = addr[31:0];
            end
        end
        if (last)
        begin
            col_pos = '0;
            row_pos = '0;
            chan_pos = '0;
        end
        else if (int'(col_pos) + 1 >= int'(cfg_out_w))
        begin
            col_pos = '0;
            if (int'(row_pos) + 1 >= int'(cfg_out_h))
            begin
                row_pos = '0;
                chan_pos = chan_pos + 16'd1;
            end
            else
                row_pos = row_pos + 16'd1;
        end
        else
            col_pos = col_pos + 16'd1;
        return r;
    endfunction

    task automatic note_mismatch(string what, out_word_t exp_w, out_word_t got_w);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected addr=%h oor=%b aerr=%b last=%b, got addr=%h oor=%b aerr=%b last=%b",
                     what, exp_w.source_address, exp_w.out_of_range, exp_w.axis_error,
                     exp_w.last_result, got_w.source_address, got_w.out_of_range,
                     got_w.axis_error, got_w.last_result);
    endtask

    // prediction on input acceptance, comparison on output acceptance
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                pending_addresses.push_back(predict_address(in_ch.data.gather_index,
                                                            in_ch.data.last_element));
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_addresses.size() == 0)
                    note_mismatch("unexpected word", '0, out_ch.data);
                else
                begin
                    exp_w = pending_addresses.pop_front();
                    if (out_ch.data.source_address !== exp_w.source_address ||
                        out_ch.data.out_of_range !== exp_w.out_of_range ||
                        out_ch.data.axis_error !== exp_w.axis_error ||
                        out_ch.data.last_result !== exp_w.last_result)
                        note_mismatch("field", exp_w, out_ch.data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_NUM_DIMS:       cfg_dims = val[1:0];
            REG_GATHER_AXIS:    cfg_axis = val[2:0];
            REG_OUT_WIDTH:      cfg_out_w = val[15:0];
            REG_OUT_HEIGHT:     cfg_out_h = val[15:0];
            REG_DATA_WIDTH:     cfg_data_w = val[15:0];
            REG_DATA_HEIGHT:    cfg_data_h = val[15:0];
            REG_DATA_CHANNELS:  cfg_data_c = val[15:0];
            REG_CHANNEL_STRIDE: cfg_stride = val;
            default: ;
        endcase
    endtask

    task automatic load_shape(int dims, int axis, int ow, int oh, int dw, int dh, int dc,
                              logic [31:0] stride);
        write_reg(REG_NUM_DIMS, dims);
        write_reg(REG_GATHER_AXIS, axis);
        write_reg(REG_OUT_WIDTH, ow);
        write_reg(REG_OUT_HEIGHT, oh);
        write_reg(REG_DATA_WIDTH, dw);
        write_reg(REG_DATA_HEIGHT, dh);
        write_reg(REG_DATA_CHANNELS, dc);
        write_reg(REG_CHANNEL_STRIDE, stride);
    endtask

    // wait for every outstanding word, then let the pipeline settle
    task automatic drain_pipeline();
        while (pending_addresses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_word(logic [31:0] gidx, logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data.gather_index = gidx;
        in_ch.data.last_element = last;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_word(32'd0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'd1, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b1);
        drain_pipeline();
    endtask

    task automatic test_directed_cases();
        // outermost axis of a full-size 3-d tensor, address wraps past 32 bits
        load_shape(3, 0, 3, 2, 65535, 65535, 65535, 32'hFFFF_FFFF);
        send_word(32'd65534, 1'b0);
        send_word(32'd0, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(-32'sd65535, 1'b0);
        send_word(-32'sd65536, 1'b0);
        send_word(32'd65535, 1'b0);
        drain_pipeline();
        // innermost axis by negative count
        write_reg(REG_GATHER_AXIS, -1);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'd65534, 1'b1);
        drain_pipeline();
        // invalid axes
        write_reg(REG_GATHER_AXIS, -4);
        send_word(32'd0, 1'b0);
        drain_pipeline();
        write_reg(REG_GATHER_AXIS, 3);
        send_word(32'd0, 1'b0);
        drain_pipeline();
        write_reg(REG_NUM_DIMS, 0);
        write_reg(REG_GATHER_AXIS, 0);
        send_word(32'd0, 1'b1);
        drain_pipeline();
        // zero output extents wrap every step
        load_shape(2, 0, 0, 0, 4, 3, 1, 32'd0);
        send_word(32'd2, 1'b0);
        send_word(-32'sd3, 1'b0);
        send_word(32'd3, 1'b0);
        drain_pipeline();
        load_shape(1, 1, 5, 1, 7, 1, 1, 32'd1);
        send_word(32'd3, 1'b0);
        drain_pipeline();
        // empty gather axis
        load_shape(1, 0, 5, 1, 0, 1, 1, 32'd1);
        send_word(32'd0, 1'b1);
        drain_pipeline();
    endtask

    function automatic int pick_extent(int typ_max);
        case ($urandom_range(19))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(1, 65535);
            default: return $urandom_range(1, typ_max);
        endcase
    endfunction

    function automatic logic [31:0] pick_index(longint len);
        if (len <= 0 || $urandom_range(9) == 0)
            return $urandom;
        case ($urandom_range(9))
            0: return len;
            1: return -len - 1;
            2, 3: return -longint'($urandom_range(1, len));
            default: return $urandom_range(0, len - 1);
        endcase
    endfunction

    task automatic randomize_shape();
        int dims;
        int axis;
        int ow;
        int oh;
        int dw;
        int dh;
        int dc;
        logic [31:0] stride;
        dims = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 3);
        if (dims == 0 || $urandom_range(4) == 0)
            axis = $urandom_range(7);
        else
        begin
            axis = $urandom_range(0, dims - 1);
            if ($urandom_range(1))
                axis = axis - dims;
        end
        ow = pick_extent(6);
        oh = pick_extent(5);
        dw = pick_extent(20);
        dh = pick_extent(20);
        dc = pick_extent(8);
        case ($urandom_range(9))
            0: stride = 32'hFFFF_FFFF;
            1: stride = $urandom;
            2: stride = 32'd0;
            default: stride = dw * dh;
        endcase
        load_shape(dims, axis, ow, oh, dw, dh, dc, stride);
    endtask

    task automatic test_random_tensors(int idle_pct, int stall_pct_in, int words);
        int     sent;
        int     n;
        int     inner;
        longint len;
        longint size;
        bit     well_formed;
        sent = 0;
        src_idle_pct = idle_pct;
        stall_pct = stall_pct_in;
        while (sent < words)
        begin
            drain_pipeline();
            randomize_shape();
            inner = gather_inner();
            len = (inner < 0) ? 0 : axis_length(inner);
            repeat ($urandom_range(1, 3))
            begin
                size = longint'(cfg_out_w) * cfg_out_h * ((cfg_dims >= 3) ? $urandom_range(1, 3) : 1);
                n = (size == 0 || size > 40) ? $urandom_range(1, 40) : size;
                well_formed = ($urandom_range(99) < 85);
                for (int i = 0; i < n; i++)
                begin
                    if (well_formed)
                        send_word(pick_index(len), i == n - 1);
                    else
                        send_word(pick_index(len), $urandom_range(9) == 0);
                    sent++;
                end
            end
        end
        drain_pipeline();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        src_idle_pct = 0;
        stall_pct = 0;
        mismatch_count = 0;
        stall_cycles = 0;
        cfg_dims = 2'd1;
        cfg_axis = 3'sd0;
        cfg_out_w = 16'd1;
        cfg_out_h = 16'd1;
        cfg_data_w = 16'd1;
        cfg_data_h = 16'd1;
        cfg_data_c = 16'd1;
        cfg_stride = 32'd1;
        col_pos = '0;
        row_pos = '0;
        chan_pos = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_random_tensors(0, 0, WORDS_PER_PHASE);
        test_random_tensors(65, 0, WORDS_PER_PHASE);
        test_random_tensors(0, 65, WORDS_PER_PHASE);
        test_random_tensors(36, 36, WORDS_PER_PHASE);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gae_pkg.sv
rtl/gae_in_if.sv
rtl/gae_out_if.sv
rtl/gather_elements_address_gen.sv
verif/tb_top.sv
